// ===== rtl/core/gtg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the go-to-goal steering block.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int SQRT_STEPS = 17;
    localparam int ATAN_LEN   = 24;
    localparam int COORD_LIM  = 24576;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;

    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_STOP_RAD  = 2'd2;
    localparam logic [1:0] REG_HEAD_TOL  = 2'd3;

    localparam logic [1:0] ST_DRIVE    = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic signed [31:0] ATAN_Q28 [ATAN_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef struct packed {
        logic [15:0] gain;
        logic [14:0] max_speed;
        logic [14:0] stop_radius;
        logic [14:0] heading_tol;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               pose;
        logic [1:0]         status;
        logic signed [14:0] heading;
        logic signed [35:0] cx;
        logic signed [35:0] cy;
        logic signed [31:0] cz;
        logic [33:0]        sv;
        logic [33:0]        sr;
    } t_cell_data;

endpackage

// ===== rtl/core/gtg_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_cfg
// APB register file: gain, speed limit, stop radius, heading tolerance.
// ----------------------------------------------------------------------------
module gtg_cfg import gtg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain        <= 16'd4096;
            r_cfg.max_speed   <= 15'd6144;
            r_cfg.stop_radius <= 15'd205;
            r_cfg.heading_tol <= 15'd819;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_GAIN:      r_cfg.gain        <= pwdata[15:0];
                REG_MAX_SPEED: r_cfg.max_speed   <= pwdata[14:0];
                REG_STOP_RAD:  r_cfg.stop_radius <= pwdata[14:0];
                REG_HEAD_TOL:  r_cfg.heading_tol <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GAIN:      prdata = {16'd0, r_cfg.gain};
            REG_MAX_SPEED: prdata = {17'd0, r_cfg.max_speed};
            REG_STOP_RAD:  prdata = {17'd0, r_cfg.stop_radius};
            REG_HEAD_TOL:  prdata = {17'd0, r_cfg.heading_tol};
            default:       prdata = 32'd0;
        endcase
    end
endmodule

// ===== rtl/core/gtg_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_cell
// One pipeline cell: one vectoring CORDIC rotation if IDX < CORDIC_STAGES, one square-root digit if IDX < SQRT_STEPS.
// ----------------------------------------------------------------------------
module gtg_cell import gtg_pkg::*; #(
    parameter int IDX           = 0,
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_data i_d,
    output t_cell_data o_d
);
    localparam int SH = (IDX < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
    localparam logic [33:0] BITC = 34'(1) << SH;

    t_cell_data r_d, n_d;
    logic signed [35:0] w_xs, w_ys;
    logic [33:0] w_trial;

    assign w_xs    = i_d.cx >>> IDX;
    assign w_ys    = i_d.cy >>> IDX;
    assign w_trial = i_d.sr + BITC;

    always_comb begin
        n_d = i_d;
        if (IDX < CORDIC_STAGES) begin
            if (i_d.cy > 0) begin
                n_d.cx = i_d.cx + w_ys;
                n_d.cy = i_d.cy - w_xs;
                n_d.cz = i_d.cz + ATAN_Q28[IDX];
            end else begin
                n_d.cx = i_d.cx - w_ys;
                n_d.cy = i_d.cy + w_xs;
                n_d.cz = i_d.cz - ATAN_Q28[IDX];
            end
        end
        if (IDX < SQRT_STEPS) begin
            if (i_d.sv >= w_trial) begin
                n_d.sv = i_d.sv - w_trial;
                n_d.sr = (i_d.sr >> 1) + BITC;
            end else begin
                n_d.sr = i_d.sr >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// ===== rtl/core/go_to_goal_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_steering
// Proportional go-to-goal controller: CORDIC bearing, digit square root.
// ----------------------------------------------------------------------------
// channel  | dir | beat contents
// s_axis   | in  | tuser: command; tdata: x_coord, y_coord, heading
// m_axis   | out | tuser: status;  tdata: forward_speed, turn_speed
// apb      | in  | gain, max_speed, stop_radius, heading_tolerance
//
// One beat per cycle in and out while the output is not stalled. Registers r0, r1, r2,
// then NCELL cells, NCELL being max(CORDIC_STAGES, 17), then r3 and the output.
// A set-target beat updates the goal when accepted; later poses see it.
// m_axis_tready low stalls the whole pipe; s_axis_tready then drops.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module go_to_goal_steering import gtg_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // x_coord, y_coord, heading, pad
    input  logic        i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // forward_speed, turn_speed, pad
    output logic [1:0]  o_m_axis_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NCELL = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    t_cfg w_cfg;
    logic w_en, w_acc;
    logic signed [15:0] w_x, w_y;
    logic signed [14:0] w_hd;
    logic w_ok;

    logic signed [15:0] r_goal_x, r_goal_y;

    // stage 0
    logic r0_valid, r0_pose;
    logic [1:0] r0_status;
    logic signed [14:0] r0_hd;
    logic signed [16:0] r0_dx, r0_dy;
    // stage 1
    logic r1_valid, r1_pose;
    logic [1:0] r1_status;
    logic signed [14:0] r1_hd;
    logic [33:0] r1_sqx, r1_sqy;
    logic signed [35:0] r1_cx, r1_cy;
    logic signed [31:0] r1_cz;
    logic signed [35:0] w_dx36, w_dy36;
    logic signed [33:0] w_sqx, w_sqy;
    // cell row
    t_cell_data r2_d;
    t_cell_data w_chain [NCELL+1];
    t_cell_data w_last;
    // post stage
    logic r3_valid, r3_pose, r3_far, r3_turn;
    logic [1:0] r3_status;
    logic [14:0] r3_mag;
    logic [32:0] r3_prod;
    logic signed [15:0] w_bear;
    logic signed [16:0] w_err;
    logic [14:0] w_mag;
    logic [20:0] w_fwd;
    // output
    logic r_ov;
    logic [14:0] r_ofwd, r_oturn;
    logic [1:0] r_ost;
    logic [14:0] n_ofwd, n_oturn;

    gtg_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    assign w_en            = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign w_x             = i_s_axis_tdata[15:0];
    assign w_y             = i_s_axis_tdata[31:16];
    assign w_hd            = i_s_axis_tdata[46:32];
    assign w_ok = (w_x > 16'sd0) && (w_x < 16'(COORD_LIM))
               && (w_y > 16'sd0) && (w_y < 16'(COORD_LIM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= 16'sd20480;
            r_goal_y <= 16'sd20480;
        end else if (w_acc && i_s_axis_tuser && w_ok) begin
            r_goal_x <= w_x;
            r_goal_y <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_pose   <= !i_s_axis_tuser;
            r0_status <= !i_s_axis_tuser ? ST_DRIVE : (w_ok ? ST_ACCEPTED : ST_REJECTED);
            r0_hd     <= w_hd;
            r0_dx     <= {r_goal_x[15], r_goal_x} - {w_x[15], w_x};
            r0_dy     <= {r_goal_y[15], r_goal_y} - {w_y[15], w_y};
        end
    end

    assign w_dx36 = {{3{r0_dx[16]}}, r0_dx, 16'd0};
    assign w_dy36 = {{3{r0_dy[16]}}, r0_dy, 16'd0};
    assign w_sqx  = r0_dx * r0_dx;
    assign w_sqy  = r0_dy * r0_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pose   <= r0_pose;
            r1_status <= r0_status;
            r1_hd     <= r0_hd;
            r1_sqx    <= w_sqx;
            r1_sqy    <= w_sqy;
            // pre-rotate into the right half plane
            if (r0_dx[16]) begin
                if (!r0_dy[16]) begin
                    r1_cx <= w_dy36;
                    r1_cy <= -w_dx36;
                    r1_cz <= HALF_PI_Q28;
                end else begin
                    r1_cx <= -w_dy36;
                    r1_cy <= w_dx36;
                    r1_cz <= -HALF_PI_Q28;
                end
            end else begin
                r1_cx <= w_dx36;
                r1_cy <= w_dy36;
                r1_cz <= 32'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_d <= '0;
        end else if (w_en) begin
            r2_d.valid   <= r1_valid;
            r2_d.pose    <= r1_pose;
            r2_d.status  <= r1_status;
            r2_d.heading <= r1_hd;
            r2_d.cx      <= r1_cx;
            r2_d.cy      <= r1_cy;
            r2_d.cz      <= r1_cz;
            r2_d.sv      <= r1_sqx + r1_sqy;
            r2_d.sr      <= 34'd0;
        end
    end

    assign w_chain[0] = r2_d;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        gtg_cell #(
            .IDX(g),
            .CORDIC_STAGES(CORDIC_STAGES)
        ) u_cell (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_d(w_chain[g]), .o_d(w_chain[g+1])
        );
    end

    assign w_last = w_chain[NCELL];
    assign w_bear = 16'((w_last.cz + 32'sd32768) >>> 16);
    assign w_err  = {w_bear[15], w_bear} - {{2{w_last.heading[14]}}, w_last.heading};
    assign w_mag  = w_err[16] ? 15'(-w_err) : w_err[14:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pose   <= w_last.pose;
            r3_status <= w_last.status;
            r3_mag    <= w_mag;
            r3_far    <= w_last.sr[16:0] > {2'd0, w_cfg.stop_radius};
            r3_turn   <= w_mag > w_cfg.heading_tol;
            r3_prod   <= w_cfg.gain * w_last.sr[16:0];
        end
    end

    assign w_fwd = r3_prod[32:12];

    always_comb begin
        n_ofwd  = 15'd0;
        n_oturn = 15'd0;
        if (r3_pose && r3_far) begin
            if (r3_turn) begin
                n_oturn = r3_mag;
            end else if (w_fwd > {6'd0, w_cfg.max_speed}) begin
                n_ofwd = w_cfg.max_speed;
            end else begin
                n_ofwd = w_fwd[14:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ofwd  <= n_ofwd;
            r_oturn <= n_oturn;
            r_ost   <= r3_status;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'd0, r_oturn, r_ofwd};
    assign o_m_axis_tuser  = r_ost;

`ifndef SYNTHESIS
    a_tgt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_DRIVE) |-> (o_m_axis_tdata == 32'd0))
        else $error("set-target beat carries nonzero speed");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:0] == 15'd0 || o_m_axis_tdata[29:15] == 15'd0))
        else $error("forward and turn both nonzero");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("bad status code");
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif
endmodule

// ===== tb/sv/go_to_goal_steering_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_steering_checker
// Watches the input stream, the register port and the output stream of the
// steering block, predicts every drive command and compares it field by field.
// ----------------------------------------------------------------------------
module go_to_goal_steering_checker import gtg_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // x_coord, y_coord, heading, pad
    input  logic        i_s_axis_tuser,   // command
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,   // forward_speed, turn_speed, pad
    input  logic [1:0]  i_m_axis_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);

    typedef struct {
        logic [14:0] fwd;
        logic [14:0] turn;
        logic [1:0]  status;
    } t_drive_cmd;

    t_drive_cmd   drive_queue[$];
    t_cfg         cfg;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int bearing_of(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = HALF_PI_Q28;
            end else begin
                x = -y;
                y = t;
                z = -longint'(HALF_PI_Q28);
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q28[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q28[i];
            end
        end
        return int'((z + 32768) >>> 16);
    endfunction

    function automatic t_drive_cmd steer(logic cmd, logic signed [15:0] x,
                                         logic signed [15:0] y,
                                         logic signed [14:0] hd);
        t_drive_cmd c;
        longint dx;
        longint dy;
        longint range_q;
        longint fwd;
        int err;
        int mag;
        c.fwd = '0;
        c.turn = '0;
        c.status = ST_DRIVE;
        if (cmd) begin
            if (x > 0 && x < COORD_LIM && y > 0 && y < COORD_LIM) begin
                goal_x = x;
                goal_y = y;
                c.status = ST_ACCEPTED;
            end else begin
                c.status = ST_REJECTED;
            end
        end else begin
            dx = longint'(goal_x) - longint'(x);
            dy = longint'(goal_y) - longint'(y);
            range_q = root_floor(dx * dx + dy * dy);
            err = bearing_of(dx, dy) - int'(hd);
            mag = (err < 0) ? -err : err;
            if (range_q > longint'(cfg.stop_radius)) begin
                if (mag > int'(cfg.heading_tol)) begin
                    c.turn = mag[14:0];
                end else begin
                    fwd = (longint'(cfg.gain) * range_q) >> 12;
                    if (fwd > longint'(cfg.max_speed)) fwd = cfg.max_speed;
                    c.fwd = fwd[14:0];
                end
            end
        end
        return c;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    t_drive_cmd want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.gain        <= 16'd4096;
            cfg.max_speed   <= 15'd6144;
            cfg.stop_radius <= 15'd205;
            cfg.heading_tol <= 15'd819;
            goal_x = 16'sd20480;
            goal_y = 16'sd20480;
            drive_queue.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (drive_queue.size() == 0) begin
                    report("unexpected beat", 32'(i_m_axis_tuser), 32'd0);
                end else begin
                    want = drive_queue.pop_front();
                    if (i_m_axis_tdata[14:0] != want.fwd)
                        report("forward_speed", 32'(i_m_axis_tdata[14:0]), 32'(want.fwd));
                    if (i_m_axis_tdata[29:15] != want.turn)
                        report("turn_speed", 32'(i_m_axis_tdata[29:15]), 32'(want.turn));
                    if (i_m_axis_tuser != want.status)
                        report("status", 32'(i_m_axis_tuser), 32'(want.status));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                drive_queue.push_back(steer(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                            i_s_axis_tdata[31:16],
                                            i_s_axis_tdata[46:32]));
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GAIN:      cfg.gain        <= pwdata[15:0];
                    REG_MAX_SPEED: cfg.max_speed   <= pwdata[14:0];
                    REG_STOP_RAD:  cfg.stop_radius <= pwdata[14:0];
                    REG_HEAD_TOL:  cfg.heading_tol <= pwdata[14:0];
                    default: ;
                endcase
            end
        end
        o_pending <= drive_queue.size();
    end

    initial o_errors = 0;

endmodule

// ===== tb/sv/go_to_goal_steering_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_steering_tb
// Drives pose and set-target beats with random gaps and output stalls across
// several register settings; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
module go_to_goal_steering_tb import gtg_pkg::*;;

    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;

    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    bit   calm;
    bit   long_hold_req;
    int   sent;

    go_to_goal_steering i_dut (.*);

    go_to_goal_steering_checker i_chk (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid, .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata, .i_s_axis_tuser,
        .i_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready,
        .i_m_axis_tdata(o_m_axis_tdata), .i_m_axis_tuser(o_m_axis_tuser),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side stalls
    initial begin
        i_m_axis_tready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(logic cmd, logic [15:0] x, logic [15:0] y, logic [14:0] hd);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {1'b0, hd, y, x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (cmd && $signed(x) > 0 && $signed(x) < COORD_LIM
            && $signed(y) > 0 && $signed(y) < COORD_LIM) begin
            goal_x = x;
            goal_y = y;
        end
        sent++;
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] g, logic [14:0] ms, logic [14:0] sr,
                            logic [14:0] tol);
        reg_write(REG_GAIN, {16'd0, g});
        reg_write(REG_MAX_SPEED, {17'd0, ms});
        reg_write(REG_STOP_RAD, {17'd0, sr});
        reg_write(REG_HEAD_TOL, {17'd0, tol});
    endtask

    task automatic random_beat(int n);
        int pick;
        int d;
        logic [14:0] hd;
        pick = $urandom_range(0, 99);
        d = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40000) : $urandom_range(0, 600);
        hd = 15'($urandom_range(0, 1200)) - 15'd600;
        if (pick < 10)
            send_beat(1'b1, 16'($urandom_range(1, COORD_LIM - 1)),
                      16'($urandom_range(1, COORD_LIM - 1)), 15'($urandom));
        else if (pick < 15)
            send_beat(1'b1, 16'($urandom), 16'($urandom), 15'($urandom));
        else if (pick < 50)
            send_beat(1'b0, goal_x - 16'(d), goal_y + 16'($urandom_range(0, 6)) - 16'd3, hd);
        else if (pick < 65)
            send_beat(1'b0, goal_x + 16'($urandom_range(0, 6)) - 16'd3, goal_y - 16'(d),
                      hd + 15'd6434);
        else if (pick < 75)
            send_beat(1'b0, goal_x + 16'($urandom_range(0, 600)) - 16'd300,
                      goal_y + 16'($urandom_range(0, 600)) - 16'd300, 15'($urandom));
        else if (pick < 90)
            send_beat(1'b0, 16'($urandom), 16'($urandom),
                      15'($urandom_range(0, 25736)) - 15'd12868);
        else
            send_beat(1'b0, 16'($urandom), 16'($urandom), 15'($urandom));
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        goal_x = 16'sd20480;
        goal_y = 16'sd20480;
        calm = 1'b0;
        long_hold_req = 1'b0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults untouched: goal at reset value
        send_beat(1'b0, 16'sd20480, 16'sd20480, 15'd0);
        send_beat(1'b0, 16'sd20480 - 16'sd100, 16'sd20480, 15'd0);
        send_beat(1'b0, 16'sd0, 16'sd20480, 15'd0);
        send_beat(1'b0, 16'h8000, 16'h8000, 15'h4000);
        send_beat(1'b0, 16'h7FFF, 16'h7FFF, 15'h3FFF);
        send_beat(1'b0, 16'h7FFF, 16'sd0, 15'sd12868);
        send_beat(1'b0, 16'h7FFF, 16'h8000, -15'sd12868);
        send_beat(1'b1, 16'sd1, 16'sd1, 15'd0);
        send_beat(1'b1, 16'sd24575, 16'sd24575, 15'h7FFF);
        send_beat(1'b1, 16'sd0, 16'sd5, 15'd0);
        send_beat(1'b1, 16'sd24576, 16'sd100, 15'd0);
        send_beat(1'b1, 16'h8000, 16'h7FFF, 15'd0);
        send_beat(1'b1, 16'sd100, 16'hFFFF, 15'd0);
        send_beat(1'b0, 16'sd24575, 16'sd24575, 15'd0);
        send_beat(1'b1, 16'sd20480, 16'sd20480, 15'd0);
        send_beat(1'b0, -16'sd4000, 16'sd20480, 15'd0);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_regs(16'hFFFF, 15'h7FFF, 15'd0, 15'd0);
                1: set_regs(16'd0, 15'd0, 15'h7FFF, 15'd25736);
                2: set_regs(16'($urandom), 15'($urandom), 15'($urandom_range(0, 400)),
                            15'($urandom_range(0, 2000)));
                3: set_regs(16'h7FFF, 15'd12000, 15'd50, 15'h7FFF);
                default: set_regs(16'd4096, 15'd6144, 15'd205, 15'd819);
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                if (phase == 2 && n == 60) long_hold_req = 1'b1;
                if (phase == 4 && n > RANDOM_ITEMS / 5 - 60) calm = 1'b1;
                random_beat(n);
            end
            wait_idle();
        end

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
